// ===== design/cfd_pkg.sv =====
// shared types, constants and the crc-16 byte update for the frame deframer
// no dependencies; imported by crc16_frame_deframer_top
`default_nettype none

package cfd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 16;
  localparam int unsigned CountW   = 32;
  localparam int unsigned KindW    = 2;
  localparam int unsigned OutDataW = 88;

  localparam logic [ByteW-1:0]  PreambleReset = 8'h55;
  localparam logic [WordW-1:0]  CrcPoly       = 16'h1021;
  localparam logic [CountW-1:0] CountMax      = '1;

  // result kinds carried on tuser
  localparam logic [KindW-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KindW-1:0] KIND_GOOD    = 2'd1;
  localparam logic [KindW-1:0] KIND_CRC_ERR = 2'd2;

  typedef enum logic [5:0] {
    PH_WAIT   = 6'b000001,
    PH_TYPE   = 6'b000010,
    PH_SENDER = 6'b000100,
    PH_LEN    = 6'b001000,
    PH_MSG    = 6'b010000,
    PH_CRC    = 6'b100000
  } phase_e;

  // msb-first crc-16 update, one byte
  function automatic logic [WordW-1:0] crc_byte(input logic [WordW-1:0] crc,
                                                input logic [ByteW-1:0] b);
    logic [WordW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[WordW-1]) begin
        c = {c[WordW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[WordW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/crc16_frame_deframer_top.sv =====
// crc16_frame_deframer_top: byte-serial frame parser with crc-16 check; uses cfd_pkg
// throughput: one byte per cycle; a byte is taken whenever the result register is free or drained
// output: a result is registered and shows on the output in the cycle after the byte that causes it is transferred
// the crc, field capture and phase step are all worked out combinationally between input and result reg
// reset (async, active low): waiting for preamble, all fields and the error count zero, preamble 0x55
`default_nettype none

module crc16_frame_deframer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: preamble byte
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // rx_byte
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // lsb up: payload_byte[7:0], payload_index[15:8], message_type[31:16],
  // src_id[47:32], payload_length[55:48], crc_error_count[87:56]
  output logic [87:0]      m_axis_tdata_o,
  output logic [1:0]       m_axis_tuser_o    // result_kind
);
  import cfd_pkg::*;

  // parser state
  phase_e             phase_q, phase_d;
  logic [ByteW-1:0]   cnt_q, cnt_d;         // byte count within the phase
  logic [WordW-1:0]   type_q, type_d;
  logic [WordW-1:0]   sender_q, sender_d;
  logic [ByteW-1:0]   len_q, len_d;
  logic [WordW-1:0]   crc_q, crc_d;
  logic [ByteW-1:0]   crc_lo_q, crc_lo_d;   // first (low) received crc byte
  logic [CountW-1:0]  err_cnt_q, err_cnt_d;
  logic [ByteW-1:0]   preamble_q;

  // result register
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q;
  logic [KindW-1:0]    out_kind_q;

  logic                accept;
  logic                emit;
  logic [KindW-1:0]    emit_kind;
  logic [ByteW-1:0]    emit_byte;
  logic [ByteW-1:0]    emit_idx;
  logic [WordW-1:0]    crc_next;
  logic [WordW-1:0]    crc_rx;
  logic [ByteW:0]      cnt_inc;

  // a new byte may enter while the held result is being taken
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign crc_next = crc_byte(crc_q, s_axis_tdata_i);
  assign crc_rx   = {s_axis_tdata_i, crc_lo_q};
  assign cnt_inc  = {1'b0, cnt_q} + 9'd1;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    type_d    = type_q;
    sender_d  = sender_q;
    len_d     = len_q;
    crc_d     = crc_q;
    crc_lo_d  = crc_lo_q;
    err_cnt_d = err_cnt_q;
    emit      = 1'b0;
    emit_kind = KIND_PAYLOAD;
    emit_byte = '0;
    emit_idx  = '0;
    if (accept) begin
      unique case (phase_q)
        PH_WAIT: begin
          if (s_axis_tdata_i == preamble_q) begin
            cnt_d   = '0;
            crc_d   = '0;
            phase_d = PH_TYPE;
          end
        end
        PH_TYPE: begin
          crc_d = crc_next;
          if (cnt_q == '0) begin
            type_d[7:0] = s_axis_tdata_i;
            cnt_d       = 8'd1;
          end else begin
            type_d[15:8] = s_axis_tdata_i;
            cnt_d        = '0;
            phase_d      = PH_SENDER;
          end
        end
        PH_SENDER: begin
          crc_d = crc_next;
          if (cnt_q == '0) begin
            sender_d[7:0] = s_axis_tdata_i;
            cnt_d         = 8'd1;
          end else begin
            sender_d[15:8] = s_axis_tdata_i;
            cnt_d          = '0;
            phase_d        = PH_LEN;
          end
        end
        PH_LEN: begin
          crc_d   = crc_next;
          len_d   = s_axis_tdata_i;
          cnt_d   = '0;
          // zero length skips straight to the crc bytes
          phase_d = (s_axis_tdata_i == '0) ? PH_CRC : PH_MSG;
        end
        PH_MSG: begin
          crc_d     = crc_next;
          emit      = 1'b1;
          emit_kind = KIND_PAYLOAD;
          emit_byte = s_axis_tdata_i;
          emit_idx  = cnt_q;
          if (cnt_inc >= {1'b0, len_q}) begin
            cnt_d   = '0;
            phase_d = PH_CRC;
          end else begin
            cnt_d = cnt_inc[ByteW-1:0];
          end
        end
        PH_CRC: begin
          if (cnt_q == '0) begin
            crc_lo_d = s_axis_tdata_i;
            cnt_d    = 8'd1;
          end else begin
            emit    = 1'b1;
            cnt_d   = '0;
            phase_d = PH_WAIT;
            if (crc_rx == crc_q) begin
              emit_kind = KIND_GOOD;
            end else begin
              emit_kind = KIND_CRC_ERR;
              // saturating error count
              if (err_cnt_q != CountMax) begin
                err_cnt_d = err_cnt_q + 32'd1;
              end
            end
          end
        end
        default: begin
          phase_d = PH_WAIT;
        end
      endcase
    end
  end

  // result register: loads on an emitting transfer, clears once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      cnt_q       <= '0;
      type_q      <= '0;
      sender_q    <= '0;
      len_q       <= '0;
      crc_q       <= '0;
      crc_lo_q    <= '0;
      err_cnt_q   <= '0;
      preamble_q  <= PreambleReset;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      type_q      <= type_d;
      sender_q    <= sender_d;
      len_q       <= len_d;
      crc_q       <= crc_d;
      crc_lo_q    <= crc_lo_d;
      err_cnt_q   <= err_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        preamble_q <= cfg_wdata_i;
      end
    end
  end

  // payload of the result, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_kind_q <= emit_kind;
      out_data_q <= {err_cnt_d, len_q, sender_q, type_q, emit_idx, emit_byte};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;

`ifndef SYNTHESIS
  // the error count only grows
  a_err_cnt_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_cnt_q >= $past(err_cnt_q))
    else $error("crc error count decreased");

  // only the three defined kinds leave the block
  a_kind_defined: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == KIND_PAYLOAD || m_axis_tuser_o == KIND_GOOD ||
                         m_axis_tuser_o == KIND_CRC_ERR))
    else $error("undefined result kind");

  // the payload phase is never entered with a zero length
  a_msg_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_MSG) |-> (len_q != '0))
    else $error("payload phase with zero length");
`endif

endmodule

`default_nettype wire
